/* design/jbf_pkg.sv */
// Shared types and constants for the JSON object byte framer.
package jbf_pkg;

  localparam int MAX_DEPTH  = 255;
  localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_QUOTE,
    CLS_BSLASH
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
  } q_entry_t;

  typedef struct packed {
    logic       push;
    q_entry_t   entry;
  } q_write_t;

  typedef struct packed {
    logic               valid;
    logic               full;
    logic [FIFO_AW:0]   level;
  } q_status_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               in_string;
    logic               escape;
  } back_status_t;

endpackage

/* design/jbf_front.sv */
// Input side: accepts bytes and tags each with its character class.
module jbf_front
  import jbf_pkg::*;
(
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  q_status_t  q_stat,
  output q_write_t   q_wr
);

  byte_class_t cls;

  always_comb begin
    unique case (in_tdata)
      CH_OPEN:   cls = CLS_OPEN;
      CH_CLOSE:  cls = CLS_CLOSE;
      CH_QUOTE:  cls = CLS_QUOTE;
      CH_BSLASH: cls = CLS_BSLASH;
      default:   cls = CLS_OTHER;
    endcase
  end

  assign in_tready      = rst_n && !q_stat.full;
  assign q_wr.push      = in_tvalid && in_tready;
  assign q_wr.entry     = '{data: in_tdata, cls: cls};

endmodule

/* design/jbf_fifo.sv */
// Short queue of classified bytes between the front and back sides.
module jbf_fifo
  import jbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_write_t  q_wr,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t q_stat
);

  q_entry_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({q_wr.push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr_r] <= q_wr.entry;
    end
  end

  assign head         = mem[rd_ptr_r];
  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign q_stat.level = count_r;

endmodule

/* design/jbf_back.sv */
// Output side: tracks strings, escapes and nesting, drops or forwards bytes.
module jbf_back
  import jbf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  q_entry_t     head,
  input  q_status_t    q_stat,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,   // [7:0] out_byte
  output logic         out_tlast,
  output logic         out_tuser,   // [0] depth_saturated
  output back_status_t stat
);

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               str_r, str_nxt;
  logic               esc_r, esc_nxt;
  logic               valid_r, valid_nxt;
  logic [7:0]         data_r, data_nxt;
  logic               last_r, last_nxt;
  logic               sat_r, sat_nxt;
  logic               emit;

  assign pop = q_stat.valid && (!valid_r || out_tready);

  always_comb begin
    depth_nxt = depth_r;
    str_nxt   = str_r;
    esc_nxt   = esc_r;
    emit      = 1'b1;
    last_nxt  = 1'b0;
    sat_nxt   = 1'b0;
    if (depth_r == '0) begin
      if (head.cls == CLS_OPEN) begin
        depth_nxt = DEPTH_W'(1);
        str_nxt   = 1'b0;
        esc_nxt   = 1'b0;
      end else begin
        emit = 1'b0;
      end
    end else if (str_r) begin
      priority if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (head.cls == CLS_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (head.cls == CLS_QUOTE) begin
        str_nxt = 1'b0;
      end else begin
        str_nxt = str_r;
      end
    end else begin
      unique case (head.cls)
        CLS_QUOTE: str_nxt = 1'b1;
        CLS_OPEN: begin
          if (depth_r >= DEPTH_W'(MAX_DEPTH)) begin
            sat_nxt = 1'b1;
          end else begin
            depth_nxt = depth_r + 1'b1;
          end
        end
        CLS_CLOSE: begin
          depth_nxt = depth_r - 1'b1;
          if (depth_r == DEPTH_W'(1)) begin
            last_nxt = 1'b1;
            str_nxt  = 1'b0;
            esc_nxt  = 1'b0;
          end
        end
        default: ;
      endcase
    end
    data_nxt = head.data;
    if (pop) begin
      valid_nxt = emit;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      str_r   <= 1'b0;
      esc_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        depth_r <= depth_nxt;
        str_r   <= str_nxt;
        esc_r   <= esc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      data_r <= data_nxt;
      last_r <= last_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid     = valid_r;
  assign out_tdata      = data_r;
  assign out_tlast      = last_r;
  assign out_tuser      = sat_r;
  assign stat.depth     = depth_r;
  assign stat.in_string = str_r;
  assign stat.escape    = esc_r;

endmodule

/* design/json_object_byte_framer.sv */
// Top level of the JSON object byte framer.
//
// Input stream: one text byte per transfer on in_tdata. Bytes outside an
// object are dropped, except the opening brace that starts one. Inside an
// object every byte leaves on the output stream, with out_tlast set on the
// closing brace that returns nesting to zero and out_tuser set on an
// opening brace that hits the depth limit (the counter holds there).
// Braces inside quoted strings do not count; a backslash in a string
// masks the byte after it.
// Throughput: one byte per cycle while the receiver keeps taking results;
// the back side updates its state as it pops each byte. An accepted byte
// is written into the queue and then into the output register.
// A four-entry queue sits between the classifier and the state tracker,
// so in_tready stays high while the receiver stalls until the queue fills;
// a result holds on the output until taken.
// Reset (rst_n low, synchronous) empties the queue, drops any pending
// result and returns to outside any object; in_tready is low in reset.
module json_object_byte_framer
  import jbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser    // [0] depth_saturated
);

  q_write_t     q_wr;
  q_status_t    q_stat;
  q_entry_t     head;
  logic         pop;
  back_status_t stat;

  jbf_front u_front (
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_wr      (q_wr)
  );

  jbf_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  jbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .stat       (stat)
  );

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.depth == '0) |-> (!stat.in_string && !stat.escape))
    else $error("string state left set outside an object");

  a_esc_in_str: assert property (@(posedge clk) disable iff (!rst_n)
    stat.escape |-> stat.in_string)
    else $error("escape pending outside a string");

  a_end_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> !out_tuser)
    else $error("end of object and saturation on one byte");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.level == (FIFO_AW + 1)'(FIFO_DEPTH)) |-> !in_tready)
    else $error("input accepted into a full queue");
`endif

endmodule

/* verif/tb_json_object_byte_framer.sv */
// Self-checking testbench for the JSON object byte framer: directed and random streams.
module tb_json_object_byte_framer;
  import jbf_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 40;
  localparam int DRAIN_CYCLES  = 10;
  localparam int PHASE_RESULTS = 80;

  localparam logic [7:0] DIRECTED [21] = '{
    8'h00, 8'hFF, CH_CLOSE, CH_QUOTE, CH_BSLASH,
    CH_OPEN, CH_QUOTE, CH_OPEN, CH_CLOSE, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH,
    CH_QUOTE, 8'h00, 8'hFF, CH_OPEN, CH_CLOSE, CH_CLOSE,
    CH_OPEN, CH_CLOSE
  };

  typedef struct packed {
    logic [7:0] data;
    logic       obj_end;
    logic       sat;
  } frame_beat_t;

  class framer_scoreboard;
    frame_beat_t        beat_q[$];
    bit [DEPTH_W-1:0]   depth;
    bit                 in_str;
    bit                 esc;
    int                 errors;
    int                 n_in;
    int                 n_results;
    int                 n_checked;
    int                 n_ends;
    int                 n_sat;
    int                 n_dropped;

    function void note_input(logic [7:0] b);
      frame_beat_t e;
      e = '{data: b, obj_end: 1'b0, sat: 1'b0};
      n_in++;
      if (depth == 0) begin
        if (b != CH_OPEN) begin
          n_dropped++;
          return;
        end
        depth = DEPTH_W'(1);
        in_str = 1'b0;
        esc = 1'b0;
      end else if (in_str) begin
        if (esc) esc = 1'b0;
        else if (b == CH_BSLASH) esc = 1'b1;
        else if (b == CH_QUOTE) in_str = 1'b0;
      end else if (b == CH_QUOTE) begin
        in_str = 1'b1;
      end else if (b == CH_OPEN) begin
        if (depth >= MAX_DEPTH) begin
          e.sat = 1'b1;
          n_sat++;
        end else begin
          depth++;
        end
      end else if (b == CH_CLOSE) begin
        depth--;
        if (depth == 0) begin
          e.obj_end = 1'b1;
          in_str = 1'b0;
          esc = 1'b0;
          n_ends++;
        end
      end
      beat_q.insert(beat_q.size(), e);
      n_results++;
    endfunction

    function void check_result(logic [7:0] d, logic l, logic s);
      frame_beat_t e;
      if (beat_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer out_tdata=%02h out_tlast=%0b out_tuser=%0b",
                 $time, d, l, s);
        return;
      end
      e = beat_q.pop_front();
      n_checked++;
      if (d !== e.data) begin
        errors++;
        $display("%0t: out_tdata expected %02h actual %02h", $time, e.data, d);
      end
      if (l !== e.obj_end) begin
        errors++;
        $display("%0t: out_tlast expected %0b actual %0b (byte %02h)",
                 $time, e.obj_end, l, d);
      end
      if (s !== e.sat) begin
        errors++;
        $display("%0t: out_tuser expected %0b actual %0b (byte %02h)",
                 $time, e.sat, s, d);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  framer_scoreboard sb;
  logic [7:0]       obj_q[$];
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_reqs = 0;
  int               hold_done = 0;
  int               hold_cnt = 0;
  int               cycle_cnt = 0;

  json_object_byte_framer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_json_object_byte_framer NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast, out_tuser);
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_cnt <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b);
  endtask

  // close out whatever object a broken sequence left open
  task automatic resync();
    while (sb.esc) send_byte(8'h61);
    while (sb.in_str) send_byte(CH_QUOTE);
    while (sb.depth != 0) send_byte(CH_CLOSE);
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_OPEN) b = CH_CLOSE;
      send_byte(b);
    end
  endtask

  task automatic send_object(input int nest_max, input int body_len, input bit may_break);
    int         d;
    int         k;
    int         r;
    int         n;
    logic [7:0] b;
    obj_q.delete();
    obj_q.insert(obj_q.size(), CH_OPEN);
    d = 1;
    for (k = 0; d > 0; k++) begin
      r = $urandom_range(0, 99);
      if (k >= body_len || (r < 15 && d > 1)) begin
        obj_q.insert(obj_q.size(), CH_CLOSE);
        d--;
      end else if (r < 30 && d < nest_max) begin
        obj_q.insert(obj_q.size(), CH_OPEN);
        d++;
      end else if (r < 50) begin
        obj_q.insert(obj_q.size(), CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 5) == 0) begin
            obj_q.insert(obj_q.size(), CH_BSLASH);
            obj_q.insert(obj_q.size(), b);
          end else begin
            if (b == CH_QUOTE || b == CH_BSLASH)
              b = ($urandom_range(0, 1) != 0) ? CH_OPEN : CH_CLOSE;
            obj_q.insert(obj_q.size(), b);
          end
        end
        obj_q.insert(obj_q.size(), CH_QUOTE);
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_OPEN || b == CH_CLOSE) b = 8'h20;
        obj_q.insert(obj_q.size(), b);
      end
    end
    if (may_break) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        n = $urandom_range(1, obj_q.size() - 1);
        while (obj_q.size() > n) void'(obj_q.pop_back());
      end else if (r < 20) begin
        obj_q.insert($urandom_range(1, obj_q.size() - 1), CH_CLOSE);
      end
    end
    for (k = 0; k < obj_q.size(); k++) send_byte(obj_q[k]);
    resync();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.beat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int goal;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    hold_reqs <= hold_reqs + 1;
    send_object(4, 40, 1'b0);
    goal = sb.n_results + PHASE_RESULTS;
    while (sb.n_results < goal) begin
      send_noise();
      send_object($urandom_range(1, 6), $urandom_range(0, 20), 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    repeat (MAX_DEPTH + 2) send_byte(CH_OPEN);
    send_byte(8'h78);
    repeat (MAX_DEPTH) send_byte(CH_CLOSE);
    wait_drained();

    run_phase(0, 0);
    run_phase(79, 0);
    run_phase(0, 79);
    run_phase(19, 19);

    if (sb.beat_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected transfers never arrived", $time, sb.beat_q.size());
    end
    $display("Streamed %0d bytes: %0d results checked, %0d objects closed, %0d saturating braces,",
             sb.n_in, sb.n_checked, sb.n_ends, sb.n_sat);
    $display("%0d bytes dropped outside objects; steady, sender-gap, receiver-stall and mixed flow",
             sb.n_dropped);
    if (sb.errors == 0) begin
      $display("tb_json_object_byte_framer OK");
    end else begin
      $display("tb_json_object_byte_framer NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
design/jbf_pkg.sv
design/jbf_front.sv
design/jbf_fifo.sv
design/jbf_back.sv
design/json_object_byte_framer.sv
verif/tb_json_object_byte_framer.sv
